// ===== rtl/stm_pkg.sv =====
package stm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 64;
  localparam int COUNT_W    = 32;
  localparam int MEAN_W     = 52;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 152;

  // Largest and smallest values that the mean may take.
  localparam logic [MEAN_W-1:0] MEAN_POS_LIM = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_NEG_LIM = {1'b1, {(MEAN_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_HIGH = 1'b0,
    REG_NUM_LOW  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX,
    DIV_DONE
  } div_state_t;

endpackage

// ===== rtl/streaming_trimmed_mean_top.sv =====
// Channel   Direction  Signals                         Contents
// s_*       in         s_tvalid s_tready s_tdata s_tlast  one sample, last mark on tlast
// m_*       out        m_tvalid m_tready m_tdata m_tuser  sum, count and mean; empty flag
// cfg_*     in         cfg_wen cfg_index cfg_wdata       num_high (0), num_low (1)
//
// One sample is taken per cycle while the pipeline runs; each sample passes the
// high store, the low store and the accumulator in turn.
// The result of a set leaves through the bit-serial divider that forms the mean,
// which takes the set when its last sample reaches the accumulator.
// A set with nothing kept skips the division and its result is offered in the next cycle.
// s_tready falls only while the last sample of a set waits at the accumulator
// and the divider still works on, or holds, the result of the previous set.
// Reset is synchronous and clears fill counts, sum, count and handshake state.
module streaming_trimmed_mean_top import stm_pkg::*; #(
  parameter int MAX_HIGH  = 10,
  parameter int MAX_LOW   = 10,
  parameter int FRAC_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] sample
  input  logic                  s_tlast,   // last_sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [63:0] kept_sum, [95:64] kept_count,
                                           // [147:96] mean_value, [151:148] zero
  output logic                  m_tuser,   // empty_set
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int HLW = $clog2(MAX_HIGH + 1);
  localparam int LLW = $clog2(MAX_LOW + 1);

  logic [HLW-1:0]             num_high;
  logic [LLW-1:0]             num_low;

  logic                       en;
  logic                       accept;
  logic signed [SAMPLE_W-1:0] sample;

  logic                       h_pass;
  logic signed [SAMPLE_W-1:0] h_out;
  logic                       l_pass;
  logic signed [SAMPLE_W-1:0] l_out;

  logic                       p1_valid;
  logic                       p1_pass;
  logic                       p1_last;
  logic signed [SAMPLE_W-1:0] p1_val;
  logic                       p2_valid;
  logic                       p2_pass;
  logic                       p2_last;
  logic signed [SAMPLE_W-1:0] p2_val;

  logic [SUM_W-1:0]           running_sum;
  logic [COUNT_W-1:0]         running_count;
  logic [SUM_W-1:0]           sum_next;
  logic [COUNT_W-1:0]         count_next;

  logic                       div_busy;
  logic                       div_start;
  logic [SUM_W-1:0]           kept_sum;
  logic [COUNT_W-1:0]         kept_count;
  logic [MEAN_W-1:0]          mean_value;
  logic                       empty_set;

  // Configuration: values above the store capacity saturate on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_high <= HLW'(1);
      num_low  <= LLW'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_NUM_HIGH: begin
          num_high <= (32'(cfg_wdata) > MAX_HIGH) ? HLW'(MAX_HIGH) : HLW'(cfg_wdata);
        end
        REG_NUM_LOW: begin
          num_low <= (32'(cfg_wdata) > MAX_LOW) ? LLW'(MAX_LOW) : LLW'(cfg_wdata);
        end
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline holds while a finished set cannot hand over to the divider.
  assign en       = !(p2_valid && p2_last && div_busy);
  assign s_tready = en;
  assign accept   = s_tvalid && en;
  assign sample   = s_tdata[SAMPLE_W-1:0];

  // First stage: the largest values of the set.
  stm_store #(.DEPTH(MAX_HIGH)) u_high (
    .clk        (clk),
    .rst        (rst),
    .keep_large (1'b1),
    .push       (accept),
    .clear      (accept && s_tlast),
    .limit      (num_high),
    .v          (sample),
    .pass       (h_pass),
    .out_value  (h_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_pass <= h_pass;
      p1_val  <= h_out;
      p1_last <= s_tlast;
    end
  end

  // Second stage: the smallest of the values that the high store let through.
  stm_store #(.DEPTH(MAX_LOW)) u_low (
    .clk        (clk),
    .rst        (rst),
    .keep_large (1'b0),
    .push       (en && p1_valid && p1_pass),
    .clear      (en && p1_valid && p1_last),
    .limit      (num_low),
    .v          (p1_val),
    .pass       (l_pass),
    .out_value  (l_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_pass <= p1_pass && l_pass;
      p2_val  <= l_out;
      p2_last <= p1_last;
    end
  end

  // Third stage: sum and count of the kept values; both wrap.
  assign sum_next   = running_sum + (p2_pass ? SUM_W'(p2_val) : '0);
  assign count_next = running_count + (p2_pass ? COUNT_W'(1) : '0);
  assign div_start  = en && p2_valid && p2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      running_count <= '0;
    end else if (en && p2_valid) begin
      if (p2_last) begin
        running_sum   <= '0;
        running_count <= '0;
      end else begin
        running_sum   <= sum_next;
        running_count <= count_next;
      end
    end
  end

  // The divider also serves as the output register of the result channel.
  stm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .sum_in     (sum_next),
    .count_in   (count_next),
    .out_ready  (m_tready),
    .busy       (div_busy),
    .out_valid  (m_tvalid),
    .kept_sum   (kept_sum),
    .kept_count (kept_count),
    .mean_value (mean_value),
    .empty_set  (empty_set)
  );

  assign m_tdata = {{(OUT_DATA_W - SUM_W - COUNT_W - MEAN_W){1'b0}},
                    mean_value, kept_count, kept_sum};
  assign m_tuser = empty_set;

endmodule

// ===== rtl/stm_cell.sv =====
module stm_cell import stm_pkg::*; (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       keep_large,
  input  logic                       valid,
  input  logic signed [SAMPLE_W-1:0] v,
  input  logic signed [SAMPLE_W-1:0] prev_value,
  input  logic                       prev_gt,
  output logic signed [SAMPLE_W-1:0] value,
  output logic                       gt
);

  logic signed [SAMPLE_W-1:0] value_next;
  logic                       ahead;

  // An empty cell always yields its place to the incoming value.
  assign ahead = keep_large ? (v > value) : (v < value);
  assign gt    = !valid || ahead;

  always_comb begin
    if (gt) begin
      value_next = prev_gt ? prev_value : v;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      value <= value_next;
    end
  end

endmodule

// ===== rtl/stm_store.sv =====
module stm_store import stm_pkg::*; #(
  parameter int DEPTH = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               keep_large,
  input  logic                               push,
  input  logic                               clear,
  input  logic [$clog2(DEPTH+1)-1:0]         limit,
  input  logic signed [SAMPLE_W-1:0]         v,
  output logic                               pass,
  output logic signed [SAMPLE_W-1:0]         out_value
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LW-1:0]              fill;
  logic [LW-1:0]              fill_next;
  logic signed [SAMPLE_W-1:0] vals [DEPTH];
  logic                       gts  [DEPTH];
  logic                       insert;
  logic [IW-1:0]              tail;

  assign insert = fill < limit;
  assign pass   = !insert;
  assign tail   = IW'(fill - LW'(1));

  // The weakest of the stored values and the new one leaves a full store.
  always_comb begin
    if (fill == '0) begin
      out_value = v;
    end else if (gts[tail]) begin
      out_value = vals[tail];
    end else begin
      out_value = v;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] prev_value;
    logic                       prev_gt;

    if (i == 0) begin : g_head
      assign prev_value = v;
      assign prev_gt    = 1'b0;
    end else begin : g_link
      assign prev_value = vals[i-1];
      assign prev_gt    = gts[i-1];
    end

    stm_cell u_cell (
      .clk        (clk),
      .we         (push),
      .keep_large (keep_large),
      .valid      (LW'(i) < fill),
      .v          (v),
      .prev_value (prev_value),
      .prev_gt    (prev_gt),
      .value      (vals[i]),
      .gt         (gts[i])
    );
  end

  always_comb begin
    if (clear) begin
      fill_next = '0;
    end else if (push && insert) begin
      fill_next = fill + LW'(1);
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

// ===== rtl/stm_div.sv =====
module stm_div import stm_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [SUM_W-1:0]          sum_in,
  input  logic [COUNT_W-1:0]        count_in,
  input  logic                      out_ready,
  output logic                      busy,
  output logic                      out_valid,
  output logic [SUM_W-1:0]          kept_sum,
  output logic [COUNT_W-1:0]        kept_count,
  output logic [MEAN_W-1:0]         mean_value,
  output logic                      empty_set
);

  localparam int DW = SUM_W + FRAC_BITS;
  localparam int CW = $clog2(DW);

  div_state_t          state;
  div_state_t          state_next;
  logic [DW-1:0]       dvd;
  logic [COUNT_W-1:0]  rem;
  logic [COUNT_W:0]    rem_sh;
  logic                ge;
  logic [MEAN_W-1:0]   quo;
  logic                ovf;
  logic                neg;
  logic [CW-1:0]       step;
  logic [SUM_W-1:0]    mag;
  logic [MEAN_W-1:0]   lim;
  logic [MEAN_W-1:0]   mag_m;

  assign mag    = sum_in[SUM_W-1] ? (~sum_in + SUM_W'(1)) : sum_in;
  assign rem_sh = {rem, dvd[DW-1]};
  assign ge     = rem_sh >= {1'b0, kept_count};
  assign lim    = neg ? MEAN_NEG_LIM : MEAN_POS_LIM;
  assign mag_m  = (ovf || (quo > lim)) ? lim : quo;

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start) begin
          state_next = (count_in == '0) ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (step == CW'(DW - 1)) begin
          state_next = DIV_FIX;
        end
      end
      DIV_FIX:  state_next = DIV_DONE;
      DIV_DONE: begin
        if (out_ready) begin
          state_next = DIV_IDLE;
        end
      end
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state)
      DIV_IDLE: busy      = 1'b0;
      DIV_DONE: out_valid = 1'b1;
      default:  busy      = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          kept_sum   <= sum_in;
          kept_count <= count_in;
          neg        <= sum_in[SUM_W-1];
          dvd        <= DW'(mag) << FRAC_BITS;
          rem        <= '0;
          quo        <= '0;
          ovf        <= 1'b0;
          step       <= '0;
          mean_value <= '0;
          empty_set  <= (count_in == '0);
        end
      end
      DIV_RUN: begin
        // One quotient bit per cycle; bits beyond the mean width only mark overflow.
        rem  <= ge ? COUNT_W'(rem_sh - {1'b0, kept_count}) : COUNT_W'(rem_sh);
        dvd  <= dvd << 1;
        quo  <= {quo[MEAN_W-2:0], ge};
        ovf  <= ovf | quo[MEAN_W-1];
        step <= step + CW'(1);
      end
      DIV_FIX: begin
        mean_value <= neg ? (~mag_m + MEAN_W'(1)) : mag_m;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/stm_checker.sv =====
module stm_checker import stm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // A result waiting for the sink keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The empty flag is set exactly when nothing was kept.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata[95:64] == '0)))
    else $error("empty flag disagrees with kept count");

  // An empty set reports a zero mean.
  a_zero_mean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[147:96] == '0))
    else $error("empty set with nonzero mean");

  // A non-negative sum never gives a negative mean.
  a_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && !m_tdata[63] |-> !m_tdata[147])
    else $error("mean sign disagrees with sum");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind streaming_trimmed_mean_top stm_checker u_stm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/streaming_trimmed_mean_top_test.sv =====
`timescale 1ns / 1ps

// Checks the trimmed sum and mean of each set against a predictor. It keeps
// the high and low stores in sorted arrays, in the same way as the block.
// A short directed part comes first: extreme samples, empty sets, single
// sample sets, stores of size zero, register saturation and a register
// lowered while a set is still open. Random phases follow, each under its own
// pair of register values. Sender and receiver idle at random, in three
// modes.
module streaming_trimmed_mean_top_test;
  import stm_pkg::*;

  localparam int STORE_DEPTH  = 10;
  localparam int FRAC         = 20;
  localparam int DRAIN_CYCLES = 120;   // three stages plus the divider
  localparam int STALL_LIMIT  = 4000;
  localparam int HIGH_SIDE    = 0;
  localparam int LOW_SIDE     = 1;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 140;

  // One expected result: the trimmed sum of a set and what follows from it.
  typedef struct packed {
    logic [SUM_W-1:0]   kept_sum;
    logic [COUNT_W-1:0] kept_count;
    logic [MEAN_W-1:0]  mean_value;
    logic               empty_set;
  } set_summary_t;

  // The class tracks the stores, the running sum and the register values. It
  // queues one summary for every sample that closes a set.
  class trim_scoreboard;
    int           store_vals [2][STORE_DEPTH];
    int unsigned  store_fill [2];
    logic [63:0]  running_sum;
    logic [31:0]  running_count;
    int unsigned  limit_high;
    int unsigned  limit_low;
    set_summary_t pending_sets[$];
    int           failures;

    function new();
      limit_high = 1;
      limit_low  = 1;
      failures   = 0;
      clear_set();
    endfunction

    function void clear_set();
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_vals[HIGH_SIDE][i] = 0;
        store_vals[LOW_SIDE][i]  = 0;
      end
      store_fill[HIGH_SIDE] = 0;
      store_fill[LOW_SIDE]  = 0;
      running_sum   = '0;
      running_count = '0;
    endfunction

    function void write_config(cfg_reg_t idx, logic [CFG_W-1:0] value);
      int unsigned v;
      v = (value > STORE_DEPTH) ? STORE_DEPTH : value;
      if (idx == REG_NUM_HIGH) begin
        limit_high = v;
      end else begin
        limit_low = v;
      end
    endfunction

    function bit ranks_ahead(bit keep_large, int a, int b);
      return keep_large ? (a > b) : (a < b);
    endfunction

    // Sorted insert, best value first. Returns 1 when a value leaves the store.
    function bit push_store(int side, bit keep_large, int unsigned limit, int v,
                            output int leaving);
      int unsigned n;
      int unsigned k;
      n = store_fill[side];
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      if (n < limit) begin
        k = n;
        while (k > 0 && ranks_ahead(keep_large, v, store_vals[side][k-1])) begin
          store_vals[side][k] = store_vals[side][k-1];
          k--;
        end
        store_vals[side][k] = v;
        store_fill[side] = n + 1;
        return 1'b0;
      end
      if (n == 0 || !ranks_ahead(keep_large, v, store_vals[side][n-1])) begin
        leaving = v;
        return 1'b1;
      end
      // The new value displaces the weakest entry, even when the store holds
      // more entries than its current limit after the register was lowered.
      leaving = store_vals[side][n-1];
      k = n - 1;
      while (k > 0 && ranks_ahead(keep_large, v, store_vals[side][k-1])) begin
        store_vals[side][k] = store_vals[side][k-1];
        k--;
      end
      store_vals[side][k] = v;
      return 1'b1;
    endfunction

    // Truncated quotient with FRAC fraction bits, saturated to the mean width.
    function logic [MEAN_W-1:0] form_mean(logic [63:0] sum, logic [31:0] count);
      logic        neg;
      logic [63:0] mag, quo, rem, lim_pos, lim_mag, m;
      neg     = sum[63];
      mag     = neg ? (~sum + 64'd1) : sum;
      quo     = mag / {32'd0, count};
      rem     = mag % {32'd0, count};
      lim_pos = (64'd1 << (MEAN_W - 1)) - 64'd1;
      lim_mag = neg ? lim_pos + 64'd1 : lim_pos;
      if (quo > (lim_mag >> FRAC)) begin
        m = lim_mag;
      end else begin
        m = (quo << FRAC) + ((rem << FRAC) / {32'd0, count});
        if (m > lim_mag) m = lim_mag;
      end
      if (neg) m = ~m + 64'd1;
      return m[MEAN_W-1:0];
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw, logic last);
      int           pushed_high, pushed_low;
      set_summary_t summary;
      if (push_store(HIGH_SIDE, 1'b1, limit_high, int'(signed'(raw)), pushed_high)) begin
        if (push_store(LOW_SIDE, 1'b0, limit_low, pushed_high, pushed_low)) begin
          running_sum   = running_sum + 64'(pushed_low);
          running_count = running_count + 32'd1;
        end
      end
      if (last) begin
        summary.kept_sum   = running_sum;
        summary.kept_count = running_count;
        summary.empty_set  = (running_count == 0);
        summary.mean_value = summary.empty_set ? '0 : form_mean(running_sum, running_count);
        pending_sets.push_back(summary);
        clear_set();
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic user);
      set_summary_t want;
      logic [MEAN_W-1:0] mean;
      if (pending_sets.size() == 0) begin
        $error("result transfer with no set summary outstanding");
        failures++;
        return;
      end
      want = pending_sets.pop_front();
      mean = data[147:96];
      if (data[63:0] !== want.kept_sum) begin
        $error("kept_sum mismatch: expected %0d, actual %0d",
               $signed(want.kept_sum), $signed(data[63:0]));
        failures++;
      end
      if (data[95:64] !== want.kept_count) begin
        $error("kept_count mismatch: expected %0d, actual %0d",
               want.kept_count, data[95:64]);
        failures++;
      end
      if (mean !== want.mean_value) begin
        $error("mean_value mismatch: expected %0d, actual %0d",
               $signed(want.mean_value), $signed(mean));
        failures++;
      end
      if (user !== want.empty_set) begin
        $error("empty_set mismatch: expected %0d, actual %0d", want.empty_set, user);
        failures++;
      end
    endfunction

    function int pending();
      return pending_sets.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_HIGH;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  trim_scoreboard sb = new();

  int          sender_idle_pct = 34;
  int          recv_idle_pct   = 58;
  int          stall_cycles    = 0;
  logic [31:0] prev_sample     = '0;

  streaming_trimmed_mean_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Both monitors sample at the rising edge, before the nonblocking updates of
  // that edge land, so they see exactly the values the block saw.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.note_sample(s_tdata[SAMPLE_W-1:0], s_tlast);
    end
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser);
    end
  end

  // The receiver stalls at random in the share that the current mode gives.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one sample after a random number of idle cycles and holds it until
  // the transfer takes place. The valid stays high into the next sample unless
  // the sender idles.
  task automatic send_sample(logic [31:0] value, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits until every summary has come back, then lets samples that close no
  // set finish their way through the stores before anything is reconfigured.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers, high then low, on consecutive edges with the enable held high.
  task automatic write_regs(logic [CFG_W-1:0] high_val, logic [CFG_W-1:0] low_val);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_NUM_HIGH;
    cfg_wdata <= high_val;
    sb.write_config(REG_NUM_HIGH, high_val);
    @(posedge clk);
    cfg_index <= REG_NUM_LOW;
    cfg_wdata <= low_val;
    sb.write_config(REG_NUM_LOW, low_val);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Mostly small values, so that ties and close orderings are common, with
  // full-range values, extremes and exact repeats mixed in.
  function automatic logic [31:0] draw_sample();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 9:    v = $urandom;
      1: begin
        case ($urandom_range(5))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          4:       v = 32'h8000_0001;
          default: v = 32'h7FFF_FFFE;
        endcase
      end
      6, 7:    v = 32'($urandom_range(2_000_000)) - 32'd1_000_000;
      8:       v = prev_sample;
      default: v = 32'($urandom_range(200)) - 32'd100;
    endcase
    prev_sample = v;
    return v;
  endfunction

  // Random sets of mixed length. Short sets give empty results, long ones
  // fill both stores. With leave_open the phase may stop in the middle of a set
  // so that the next register values apply to a set already under way.
  task automatic run_random_phase(int budget, bit leave_open);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(9))
        0, 1:    len = $urandom_range(1, 3);
        8, 9:    len = $urandom_range(20, 60);
        default: len = $urandom_range(1, 26);
      endcase
      for (int i = 0; i < len; i++) begin
        if (leave_open && sent >= budget) break;
        send_sample(draw_sample(), i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] high_vals [NUM_PHASES];
    logic [CFG_W-1:0] low_vals  [NUM_PHASES];
    high_vals = '{4'd1, 4'd0, 4'd10, 4'd15, 4'd0, 4'd10, 4'd3, 4'd7, 4'd2, 4'd12, 4'd5, 4'd1};
    low_vals  = '{4'd1, 4'd0, 4'd10, 4'd15, 4'd10, 4'd0, 4'd4, 4'd2, 4'd9, 4'd3, 4'd0, 4'd6};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: one largest and one smallest discarded. The extremes fall
    // into the stores, and sets too short to keep anything come back empty.
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'd5, 1'b1);
    send_sample(32'd7, 1'b0);
    send_sample(32'd8, 1'b1);
    send_sample(32'd3, 1'b1);

    // Values above the store depth saturate. The set is left open with the
    // high store full and the low store partly filled.
    drain();
    write_regs(4'd15, 4'd15);
    for (int i = 0; i < 14; i++) begin
      send_sample(32'(i * 1000 - 7000), 1'b0);
    end

    // Both limits are lowered while the set is open. The stores keep their
    // extra entries, and each new sample now pushes one value out.
    drain();
    write_regs(4'd1, 4'd2);
    send_sample(32'd50, 1'b0);
    send_sample(-32'sd50, 1'b0);
    send_sample(32'd0, 1'b1);

    // Stores of size zero pass everything on: largest sum and most negative mean.
    drain();
    write_regs(4'd0, 4'd0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == NUM_PHASES / 3) begin
        sender_idle_pct = 58;
        recv_idle_pct   = 34;
      end else if (p == 2 * NUM_PHASES / 3) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      write_regs(high_vals[p], low_vals[p]);
      run_random_phase(PHASE_ITEMS, (p != NUM_PHASES - 1) && ($urandom_range(2) == 0));
    end

    drain();
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
